>>> design/ball_intake_sequencer_core_macros.svh
// Assertion helpers for the intake sequencer core.
`ifndef BALL_INTAKE_SEQUENCER_CORE_MACROS_SVH
`define BALL_INTAKE_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bis_pkg.sv
package bis_pkg;

	// Drive values are milli-units of full scale.
	localparam int DRIVE_W     = 10;
	localparam int DRIVE_LIMIT = 1000;
	localparam int FULL_SCALE  = 1000;
	localparam logic [DRIVE_W-1:0] FULL_DRIVE =
		DRIVE_W'((FULL_SCALE > DRIVE_LIMIT) ? DRIVE_LIMIT : FULL_SCALE);

	// Default capacity of the ball store.
	localparam int MAX_BALLS_DEF = 15;

	// Field widths that the interface fixes.
	localparam int COUNT_OUT_W = 4;
	localparam int STEP_W      = 2;
	localparam int CFG_IDX_W   = 2;

	// Register reset values.
	localparam logic [COUNT_OUT_W-1:0] START_COUNT_RST   = '0;
	localparam logic [DRIVE_W-1:0]     INTAKE_SPEED_RST  = DRIVE_W'(500);
	localparam logic [DRIVE_W-1:0]     CONVEYOR_BASE_RST = DRIVE_W'(500);
	localparam logic [DRIVE_W-1:0]     CONVEYOR_STEP_RST = DRIVE_W'(75);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_COUNT   = 2'd0,
		REG_INTAKE_SPEED  = 2'd1,
		REG_CONVEYOR_BASE = 2'd2,
		REG_CONVEYOR_STEP = 2'd3
	} cfg_reg_t;

	// Pickup phase, one-hot.
	typedef enum logic [2:0] {
		PH_WAIT = 3'b001,
		PH_MOVE = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	// Codes reported on the pickup step output.
	localparam logic [STEP_W-1:0] STEP_WAIT = 2'd0;
	localparam logic [STEP_W-1:0] STEP_MOVE = 2'd1;
	localparam logic [STEP_W-1:0] STEP_DONE = 2'd2;

	// Clamp a register-sized drive value at the drive limit.
	function automatic logic [DRIVE_W-1:0] clamp_drive(input logic [DRIVE_W-1:0] v);
		clamp_drive = (v > DRIVE_W'(DRIVE_LIMIT)) ? DRIVE_W'(DRIVE_LIMIT) : v;
	endfunction

endpackage

>>> design/ball_intake_sequencer_core.sv
// Ball intake sequencer core.
// Each input item is one control tick: button levels, pickup and release
// sensor levels, and start, stop and eject requests. Each tick gives exactly
// one result item: conveyor drive, roller drive, ball count and pickup step.
// Both item channels use valid and stall; an item moves at a clock edge with
// valid high and stall low. The configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) is always ready; the user must write it only while the
// block is idle, which the block itself does not enforce. Writing the start
// count also reloads the ball count. An accepted tick is held in the input
// register, and its result enters the output register when the input register
// moves on, which a stall of the receiver can delay.
// Throughput is one tick per cycle while the receiver does not stall; the state
// update between the input and output registers is short enough for that.
// When the receiver stalls, the result holds in the output register, one more
// tick waits in the input register, and in_stall then rises.
// Reset clears both registers and the control state and loads the register
// reset values; the ball count starts at the reset start count.
`include "ball_intake_sequencer_core_macros.svh"

module ball_intake_sequencer_core #(
	parameter int MAX_BALLS = bis_pkg::MAX_BALLS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// Tick input channel.
	input  logic in_valid,
	output logic in_stall,
	input  logic eject_button,
	input  logic toggle_button,
	input  logic pickup_clear,
	input  logic release_clear,
	input  logic start_request,
	input  logic stop_request,
	input  logic eject_request,

	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bis_pkg::DRIVE_W-1:0]       conveyor_drive,
	output logic [bis_pkg::DRIVE_W-1:0]       intake_drive,
	output logic [bis_pkg::COUNT_OUT_W-1:0]   stored_balls,
	output logic [bis_pkg::STEP_W-1:0]        pickup_step,

	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bis_pkg::DRIVE_W-1:0]       cfg_data
);

	localparam int CNT_W  = $clog2(MAX_BALLS + 1);
	localparam int LOAD_W = (CNT_W > bis_pkg::COUNT_OUT_W) ? CNT_W : bis_pkg::COUNT_OUT_W;
	localparam int PROD_W = bis_pkg::DRIVE_W + CNT_W + 1;
	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BALLS);
	localparam logic [LOAD_W-1:0] MAX_LOAD = LOAD_W'(MAX_BALLS);

	// Configuration registers.
	logic [bis_pkg::DRIVE_W-1:0]     intake_speed_q;
	logic [bis_pkg::DRIVE_W-1:0]     conveyor_base_q;
	logic [bis_pkg::DRIVE_W-1:0]     conveyor_step_q;

	// Sequencer state.
	bis_pkg::phase_t phase_q;
	logic            intake_on_q;
	logic            button_held_q;
	logic            eject_pending_q;
	logic            ball_at_exit_q;
	logic [CNT_W-1:0] count_q;

	// Input register.
	logic valid_s1;
	logic eject_button_s1;
	logic toggle_button_s1;
	logic pickup_clear_s1;
	logic release_clear_s1;
	logic start_request_s1;
	logic stop_request_s1;
	logic eject_request_s1;

	// Output register.
	logic                            out_valid_q;
	logic [bis_pkg::DRIVE_W-1:0]     conveyor_q;
	logic [bis_pkg::DRIVE_W-1:0]     intake_q;
	logic [bis_pkg::COUNT_OUT_W-1:0] stored_q;
	logic [bis_pkg::STEP_W-1:0]      step_q;

	// Next-state and result logic.
	logic                        advance;
	logic                        accept;
	logic                        cfg_write;
	logic [CNT_W-1:0]            cfg_load_count;
	logic [LOAD_W-1:0]           start_ext;
	logic                        on_n;
	logic                        pending_n;
	logic                        held_n;
	bis_pkg::phase_t             phase_n;
	logic [CNT_W-1:0]            count_n;
	logic [bis_pkg::DRIVE_W-1:0] conv_n;
	logic [bis_pkg::DRIVE_W-1:0] roll_n;
	logic [PROD_W-1:0]           ramp_sum;
	logic [bis_pkg::DRIVE_W-1:0] ramp_drive;
	logic [LOAD_W-1:0]           count_ext;
	logic [bis_pkg::STEP_W-1:0]  step_n;

	// Handshakes: the input register moves on whenever the output register
	// is empty or being taken.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// A start count above capacity loads the capacity.
	assign start_ext      = LOAD_W'(cfg_data[bis_pkg::COUNT_OUT_W-1:0]);
	assign cfg_load_count = CNT_W'((start_ext > MAX_LOAD) ? MAX_LOAD : start_ext);

	// Phase-one conveyor ramp grows with the stored count.
	assign ramp_sum   = PROD_W'(conveyor_base_q) + PROD_W'(conveyor_step_q) * PROD_W'(count_q);
	assign ramp_drive = (ramp_sum > PROD_W'(bis_pkg::DRIVE_LIMIT)) ?
		bis_pkg::DRIVE_W'(bis_pkg::DRIVE_LIMIT) : ramp_sum[bis_pkg::DRIVE_W-1:0];

	// One tick of the sequencer.
	always_comb begin
		on_n      = intake_on_q;
		pending_n = eject_pending_q || eject_request_s1;
		held_n    = button_held_q;
		phase_n   = phase_q;
		count_n   = count_q;
		conv_n    = '0;
		roll_n    = '0;

		// Requests apply first, and stop wins over start.
		if (stop_request_s1) begin
			on_n = 1'b0;
		end else if (start_request_s1) begin
			on_n = 1'b1;
		end

		if (eject_button_s1 || pending_n) begin
			// Eject: full speed, count balls leaving past the release sensor.
			phase_n = bis_pkg::PH_WAIT;
			if (ball_at_exit_q && release_clear_s1 && (count_q != '0)) begin
				count_n = count_q - CNT_W'(1);
			end
			if (pending_n && (count_n == '0)) begin
				pending_n = 1'b0;
			end else begin
				conv_n = bis_pkg::FULL_DRIVE;
				roll_n = bis_pkg::FULL_DRIVE;
			end
		end else begin
			// A rising edge of the toggle button flips the intake.
			if (toggle_button_s1) begin
				if (!button_held_q) begin
					on_n = !on_n;
				end
				held_n = 1'b1;
			end else begin
				held_n = 1'b0;
			end

			if (on_n && release_clear_s1) begin
				unique case (phase_q)
					bis_pkg::PH_WAIT: begin
						if (!pickup_clear_s1) begin
							if (count_q < MAX_CNT) begin
								count_n = count_q + CNT_W'(1);
							end
							phase_n = bis_pkg::PH_MOVE;
							conv_n  = bis_pkg::clamp_drive(conveyor_base_q);
						end else begin
							roll_n = bis_pkg::clamp_drive(intake_speed_q);
						end
					end
					bis_pkg::PH_MOVE: begin
						if (pickup_clear_s1) begin
							phase_n = bis_pkg::PH_DONE;
						end else begin
							conv_n = ramp_drive;
						end
					end
					default: begin
						on_n = 1'b0;
					end
				endcase
			end else begin
				phase_n = bis_pkg::PH_WAIT;
				roll_n  = on_n ? bis_pkg::clamp_drive(intake_speed_q) : '0;
			end
		end
	end

	// Report the phase after the tick as a step code.
	always_comb begin
		unique case (phase_n)
			bis_pkg::PH_WAIT: step_n = bis_pkg::STEP_WAIT;
			bis_pkg::PH_MOVE: step_n = bis_pkg::STEP_MOVE;
			default:          step_n = bis_pkg::STEP_DONE;
		endcase
	end

	assign count_ext = LOAD_W'(count_n);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intake_speed_q  <= bis_pkg::INTAKE_SPEED_RST;
			conveyor_base_q <= bis_pkg::CONVEYOR_BASE_RST;
			conveyor_step_q <= bis_pkg::CONVEYOR_STEP_RST;
		end else if (cfg_write) begin
			unique case (bis_pkg::cfg_reg_t'(cfg_index))
				// The start count only loads the ball count.
				bis_pkg::REG_START_COUNT:   ;
				bis_pkg::REG_INTAKE_SPEED:  intake_speed_q  <= cfg_data;
				bis_pkg::REG_CONVEYOR_BASE: conveyor_base_q <= cfg_data;
				bis_pkg::REG_CONVEYOR_STEP: conveyor_step_q <= cfg_data;
			endcase
		end
	end

	// Sequencer state; a start count write reloads the ball count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= bis_pkg::PH_WAIT;
			intake_on_q     <= 1'b0;
			button_held_q   <= 1'b0;
			eject_pending_q <= 1'b0;
			ball_at_exit_q  <= 1'b0;
			count_q         <= CNT_W'((LOAD_W'(bis_pkg::START_COUNT_RST) > MAX_LOAD) ?
				MAX_LOAD : LOAD_W'(bis_pkg::START_COUNT_RST));
		end else begin
			if (advance) begin
				phase_q         <= phase_n;
				intake_on_q     <= on_n;
				button_held_q   <= held_n;
				eject_pending_q <= pending_n;
				ball_at_exit_q  <= !release_clear_s1;
				count_q         <= count_n;
			end
			if (cfg_write && (bis_pkg::cfg_reg_t'(cfg_index) == bis_pkg::REG_START_COUNT)) begin
				count_q <= cfg_load_count;
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			eject_button_s1  <= eject_button;
			toggle_button_s1 <= toggle_button;
			pickup_clear_s1  <= pickup_clear;
			release_clear_s1 <= release_clear;
			start_request_s1 <= start_request;
			stop_request_s1  <= stop_request;
			eject_request_s1 <= eject_request;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			conveyor_q <= conv_n;
			intake_q   <= roll_n;
			stored_q   <= count_ext[bis_pkg::COUNT_OUT_W-1:0];
			step_q     <= step_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign conveyor_drive = conveyor_q;
	assign intake_drive   = intake_q;
	assign stored_balls   = stored_q;
	assign pickup_step    = step_q;

	// Both motors run together only at full speed during an eject.
	`BIS_ASSERT_SAME(a_motors_overlap, clk, arst_n,
		out_valid_q && (conveyor_q != '0) && (intake_q != '0),
		(conveyor_q == bis_pkg::FULL_DRIVE) && (intake_q == bis_pkg::FULL_DRIVE),
		"both motors driven outside eject")

	// The ball count never passes the store capacity.
	`BIS_ASSERT_SAME(a_count_limit, clk, arst_n, 1'b1, count_q <= MAX_CNT,
		"ball count above capacity")

	// A tick that leaves the input register always lands in the output register.
	`BIS_ASSERT_NEXT(a_result_lands, clk, arst_n, advance, out_valid_q,
		"tick result lost between registers")

endmodule
